@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and helpers shared by the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS     = 4096;
  localparam int MIN_BLOCK_LOG2 = 10;
  localparam int IDX_W          = $clog2(MAX_BLOCKS);
  localparam int CNT_W          = IDX_W + 1;
  localparam int LAYER_W        = 4;
  localparam int SIZE_W         = 22;
  localparam int OFF_W          = 22;
  localparam int WIDE_W         = 38;
  localparam int SH_W           = 5;

  localparam logic [LAYER_W-1:0] TOP_LAYER = LAYER_W'(IDX_W);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [SIZE_W-1:0]   size_bytes;
    logic [OFF_W-1:0]    free_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFF_W-1:0]    block_offset;
    logic [LAYER_W-1:0]  block_layer;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [LAYER_W-1:0]  layer;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    addr;
    entry_t              wdata;
  } ram_req_t;

  localparam entry_t TOP_ENTRY = '{idx: '0, layer: TOP_LAYER};

  // byte offset of a block, full width
  function automatic logic [WIDE_W-1:0] blk_wide(entry_t e);
    logic [SH_W-1:0] sh;
    sh = SH_W'(e.layer) + SH_W'(MIN_BLOCK_LOG2);
    blk_wide = WIDE_W'(e.idx) << sh;
  endfunction

  // round size up to a power of two, then to a layer (clamped at zero)
  function automatic logic [LAYER_W-1:0] layer_of_size(logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] m;
    logic [SH_W-1:0]   k;
    m = sz - SIZE_W'(1);
    k = '0;
    for (int b = 0; b < SIZE_W; b++) begin
      if (m[b]) k = SH_W'(b + 1);
    end
    if (sz <= SIZE_W'(1)) k = '0;
    layer_of_size = (k > SH_W'(MIN_BLOCK_LOG2)) ? LAYER_W'(k - SH_W'(MIN_BLOCK_LOG2)) : '0;
  endfunction

endpackage

@@ design/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Single-port list memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module bba_ram import bba_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: scans, splits and merges over the free and used lists.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  output logic     res_valid,
  output out_t     res_data,
  input  logic     res_ready,
  output ram_req_t free_req,
  input  entry_t   free_rdata,
  output ram_req_t used_req,
  input  entry_t   used_rdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_A_SCAN, S_A_CHK, S_A_SWRD, S_A_SWWR, S_A_LO, S_A_HI,
    S_A_FIN, S_A_FWR, S_A_USED, S_F_SCAN, S_F_URD, S_F_UWR, S_F_FADD,
    S_M_SCAN, S_M_RD, S_M_WR, S_M_ADD, S_RESP
  } state_t;

  localparam logic [SH_W-1:0] NO_LAYER = '1;
  localparam logic [CNT_W:0]  MAX_W    = (CNT_W+1)'(MAX_BLOCKS);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt, uc_r, uc_nxt;
  logic [CNT_W-1:0]   scan_i_r, scan_i_nxt, lim_r, lim_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   q_r, q_nxt, cur_i_r, cur_i_nxt, found_i_r, found_i_nxt;
  logic [SH_W-1:0]    best_layer_r, best_layer_nxt;
  logic [LAYER_W-1:0] req_layer_r, req_layer_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  entry_t             cur_r, cur_nxt, orig_r, orig_nxt;
  out_t               res_r, res_nxt;
  logic               e0w_r, def_r;

  entry_t             free_rd;
  logic [CNT_W-1:0]   fc_m1, fc_m2, uc_m1;
  logic               scan_issue, scan_done, hit;
  logic [WIDE_W-1:0]  wide;
  entry_t             lower;

  assign fc_m1      = fc_r - CNT_W'(1);
  assign fc_m2      = fc_r - CNT_W'(2);
  assign uc_m1      = uc_r - CNT_W'(1);
  // entry 0 holds the whole chunk until first written
  assign free_rd    = def_r ? TOP_ENTRY : free_rdata;
  assign scan_issue = scan_i_r < lim_r;
  assign scan_done  = !pend_r && !scan_issue;
  assign lower      = '{idx: {cur_r.idx[IDX_W-2:0], 1'b0}, layer: cur_r.layer - LAYER_W'(1)};

  always_comb begin
    state_nxt      = state_r;
    fc_nxt         = fc_r;
    uc_nxt         = uc_r;
    scan_i_nxt     = scan_i_r;
    lim_nxt        = lim_r;
    pend_nxt       = pend_r;
    q_nxt          = q_r;
    cur_i_nxt      = cur_i_r;
    found_i_nxt    = found_i_r;
    best_layer_nxt = best_layer_r;
    req_layer_nxt  = req_layer_r;
    off_nxt        = off_r;
    cur_nxt        = cur_r;
    orig_nxt       = orig_r;
    res_nxt        = res_r;
    free_req       = '{we: 1'b0, addr: scan_i_r[IDX_W-1:0], wdata: '0};
    used_req       = '{we: 1'b0, addr: scan_i_r[IDX_W-1:0], wdata: '0};
    res_valid      = 1'b0;
    res_data       = res_r;
    in_stall       = (state_r != S_IDLE);
    hit            = 1'b0;
    wide           = blk_wide(cur_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_layer_nxt  = layer_of_size(in_data.size_bytes);
          off_nxt        = in_data.free_offset;
          scan_i_nxt     = '0;
          pend_nxt       = 1'b0;
          best_layer_nxt = NO_LAYER;
          if (in_data.req_type == REQ_ALLOC) begin
            lim_nxt   = fc_r;
            state_nxt = S_A_SCAN;
          end else begin
            lim_nxt   = uc_r;
            state_nxt = S_F_SCAN;
          end
        end
      end
      S_A_SCAN: begin
        if (pend_r && free_rd.layer >= req_layer_r
            && SH_W'(free_rd.layer) < best_layer_r) begin
          best_layer_nxt = SH_W'(free_rd.layer);
          cur_i_nxt      = q_r;
          cur_nxt        = free_rd;
        end
        pend_nxt = scan_issue;
        if (scan_issue) begin
          q_nxt      = scan_i_r[IDX_W-1:0];
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end
        if (scan_done) begin
          if (best_layer_r == NO_LAYER || uc_r >= CNT_W'(MAX_BLOCKS)) begin
            res_nxt   = '{status: ST_NO_SPACE, block_offset: '0, block_layer: '0};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_A_CHK;
          end
        end
      end
      S_A_CHK: begin
        if (cur_r.layer > req_layer_r && fc_r != '0 && fc_r <= CNT_W'(MAX_BLOCKS))
          state_nxt = S_A_SWRD;
        else
          state_nxt = S_A_FIN;
      end
      S_A_SWRD: begin
        free_req.addr = fc_m1[IDX_W-1:0];
        state_nxt     = S_A_SWWR;
      end
      S_A_SWWR: begin
        free_req  = '{we: 1'b1, addr: cur_i_r, wdata: free_rd};
        fc_nxt    = fc_m1;
        // no room for both halves: keep the parent
        if (({1'b0, fc_r} + (CNT_W+1)'(1)) > MAX_W) state_nxt = S_A_FIN;
        else state_nxt = S_A_LO;
      end
      S_A_LO: begin
        free_req  = '{we: 1'b1, addr: fc_r[IDX_W-1:0], wdata: lower};
        state_nxt = S_A_HI;
      end
      S_A_HI: begin
        free_req  = '{we: 1'b1, addr: fc_r[IDX_W-1:0] + IDX_W'(1),
                      wdata: '{idx: {cur_r.idx[IDX_W-2:0], 1'b1}, layer: lower.layer}};
        cur_i_nxt = fc_r[IDX_W-1:0];
        cur_nxt   = lower;
        fc_nxt    = fc_r + CNT_W'(2);
        state_nxt = S_A_CHK;
      end
      S_A_FIN: begin
        if (fc_r != '0 && fc_r <= CNT_W'(MAX_BLOCKS) && CNT_W'(cur_i_r) < fc_r) begin
          free_req.addr = fc_m1[IDX_W-1:0];
          state_nxt     = S_A_FWR;
        end else begin
          state_nxt = S_A_USED;
        end
      end
      S_A_FWR: begin
        free_req  = '{we: 1'b1, addr: cur_i_r, wdata: free_rd};
        fc_nxt    = fc_m1;
        state_nxt = S_A_USED;
      end
      S_A_USED: begin
        used_req  = '{we: 1'b1, addr: uc_r[IDX_W-1:0], wdata: cur_r};
        uc_nxt    = uc_r + CNT_W'(1);
        res_nxt   = '{status: ST_OK, block_offset: wide[OFF_W-1:0],
                      block_layer: cur_r.layer};
        state_nxt = S_RESP;
      end
      S_F_SCAN: begin
        wide = blk_wide(used_rdata);
        hit  = pend_r && (wide == WIDE_W'(off_r));
        if (hit) begin
          pend_nxt = 1'b0;
          if (fc_r >= CNT_W'(MAX_BLOCKS)) begin
            res_nxt   = '{status: ST_NOT_ALLOC, block_offset: '0, block_layer: '0};
            state_nxt = S_RESP;
          end else begin
            found_i_nxt = q_r;
            cur_nxt     = used_rdata;
            orig_nxt    = used_rdata;
            state_nxt   = S_F_URD;
          end
        end else begin
          pend_nxt = scan_issue;
          if (scan_issue) begin
            q_nxt      = scan_i_r[IDX_W-1:0];
            scan_i_nxt = scan_i_r + CNT_W'(1);
          end
          if (scan_done) begin
            res_nxt   = '{status: ST_NOT_ALLOC, block_offset: '0, block_layer: '0};
            state_nxt = S_RESP;
          end
        end
      end
      S_F_URD: begin
        used_req.addr = uc_m1[IDX_W-1:0];
        state_nxt     = S_F_UWR;
      end
      S_F_UWR: begin
        used_req  = '{we: 1'b1, addr: found_i_r, wdata: used_rdata};
        uc_nxt    = uc_m1;
        state_nxt = S_F_FADD;
      end
      S_F_FADD, S_M_ADD: begin
        free_req   = '{we: 1'b1, addr: fc_r[IDX_W-1:0], wdata: cur_r};
        fc_nxt     = fc_r + CNT_W'(1);
        lim_nxt    = fc_r;
        scan_i_nxt = '0;
        pend_nxt   = 1'b0;
        state_nxt  = S_M_SCAN;
      end
      S_M_SCAN: begin
        // buddy: same layer, index equal but for bit 0
        hit = pend_r && free_rd.idx[IDX_W-1:1] == cur_r.idx[IDX_W-1:1]
              && free_rd.layer == cur_r.layer;
        if (hit) begin
          pend_nxt    = 1'b0;
          found_i_nxt = q_r;
          state_nxt   = S_M_RD;
        end else begin
          pend_nxt = scan_issue;
          if (scan_issue) begin
            q_nxt      = scan_i_r[IDX_W-1:0];
            scan_i_nxt = scan_i_r + CNT_W'(1);
          end
          if (scan_done) begin
            wide      = blk_wide(orig_r);
            res_nxt   = '{status: ST_OK, block_offset: wide[OFF_W-1:0],
                          block_layer: orig_r.layer};
            state_nxt = S_RESP;
          end
        end
      end
      S_M_RD: begin
        free_req.addr = fc_m2[IDX_W-1:0];
        state_nxt     = S_M_WR;
      end
      S_M_WR: begin
        free_req  = '{we: 1'b1, addr: found_i_r, wdata: free_rd};
        fc_nxt    = fc_m2;
        cur_nxt   = '{idx: {1'b0, cur_r.idx[IDX_W-1:1]}, layer: cur_r.layer + LAYER_W'(1)};
        state_nxt = S_M_ADD;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fc_r    <= CNT_W'(1);
      uc_r    <= '0;
      pend_r  <= 1'b0;
      e0w_r   <= 1'b0;
      def_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      uc_r    <= uc_nxt;
      pend_r  <= pend_nxt;
      e0w_r   <= e0w_r | (free_req.we && free_req.addr == '0);
      def_r   <= (free_req.addr == '0) && !e0w_r;
    end
    scan_i_r     <= scan_i_nxt;
    lim_r        <= lim_nxt;
    q_r          <= q_nxt;
    cur_i_r      <= cur_i_nxt;
    found_i_r    <= found_i_nxt;
    best_layer_r <= best_layer_nxt;
    req_layer_r  <= req_layer_nxt;
    off_r        <= off_nxt;
    cur_r        <= cur_nxt;
    orig_r       <= orig_nxt;
    res_r        <= res_nxt;
  end

endmodule

@@ design/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over one chunk, free and used lists held in two memories.
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_stall/in_data: allocate a size or free an
// offset. Each request gives one result on out_valid/out_stall/out_data.
// One request is worked on at a time; in_stall is high while it runs.
// An allocate scans the free list (one entry a cycle) for the smallest block
// that fits, then splits it down to the requested layer and moves it to the
// used list. A free scans the used list, moves the block to the free list,
// then per merge scans the free list and rewrites it. Each list memory has
// a single port, so the list accesses of a request run one after another.
// A result is registered in the controller and then in an output register;
// a stalled result holds while the next request is already taken.
// Reset (synchronous, rst_n low) leaves the whole chunk as one free block,
// with no clearing pass: entry 0 of the free list reads as that block until
// first written.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  ram_req_t free_req, used_req;
  entry_t   free_rdata, used_rdata;
  logic     res_valid, res_ready;
  out_t     res_data;
  logic     out_valid_r;
  out_t     out_data_r;

  bba_ram u_free_ram (.clk(clk), .req(free_req), .rdata(free_rdata));
  bba_ram u_used_ram (.clk(clk), .req(used_req), .rdata(used_rdata));

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .free_req  (free_req),
    .free_rdata(free_rdata),
    .used_req  (used_req),
    .used_rdata(used_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.block_offset == '0 && out_data.block_layer == '0)
    else $error("failed request carries nonzero block fields");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("pending result lost while output is stalled");

endmodule

@@ verif/buddy_block_allocator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// Drives allocate and free requests into the buddy allocator and checks each
// result against a behavioral copy of the free and used lists.
// ----------------------------------------------------------------------------
module buddy_block_allocator_test;
  import bba_pkg::*;

  typedef struct {
    int unsigned idx;
    int unsigned layer;
  } blk_s;

  class alloc_scoreboard;
    blk_s  free_list[$];
    blk_s  used_list[$];
    out_t  pending[$];
    int    errors;

    function void clear();
      blk_s b;
      b.idx = 0;
      b.layer = IDX_W;
      free_list.delete();
      used_list.delete();
      pending.delete();
      free_list.push_back(b);
      errors = 0;
    endfunction

    function int unsigned size_layer(int unsigned sz);
      int unsigned k;
      k = 0;
      while (k < 31 && (64'd1 << k) < sz) k++;
      return (k > MIN_BLOCK_LOG2) ? k - MIN_BLOCK_LOG2 : 0;
    endfunction

    function longint unsigned byte_off(blk_s b);
      return longint'(b.idx) << (b.layer + MIN_BLOCK_LOG2);
    endfunction

    // swap-with-last removal, as the hardware lists do it
    function void drop_free(int i);
      free_list[i] = free_list[free_list.size() - 1];
      free_list.pop_back();
    endfunction

    function void note_request(in_t r);
      out_t  res;
      blk_s  cur, half, orig;
      int    best, ci, found, cnt;
      int unsigned want, bl;
      bit    merged;
      res = '0;
      if (r.req_type == REQ_ALLOC) begin
        want = size_layer(32'(r.size_bytes));
        best = -1;
        bl = 32'hffff_ffff;
        foreach (free_list[i])
          if (free_list[i].layer >= want && free_list[i].layer < bl) begin
            bl = free_list[i].layer;
            best = i;
          end
        if (best < 0 || used_list.size() >= MAX_BLOCKS) begin
          res.status = ST_NO_SPACE;
        end else begin
          ci = best;
          cur = free_list[ci];
          while (cur.layer > want) begin
            drop_free(ci);
            half.layer = cur.layer - 1;
            half.idx = cur.idx * 2;
            free_list.push_back(half);
            ci = free_list.size() - 1;
            half.idx = cur.idx * 2 + 1;
            free_list.push_back(half);
            cur = free_list[ci];
          end
          drop_free(ci);
          used_list.push_back(cur);
          res.status = ST_OK;
          res.block_offset = OFF_W'(byte_off(cur));
          res.block_layer = LAYER_W'(cur.layer);
        end
      end else begin
        found = -1;
        foreach (used_list[i])
          if (found < 0 && byte_off(used_list[i]) == r.free_offset) found = i;
        if (found < 0 || free_list.size() >= MAX_BLOCKS) begin
          res.status = ST_NOT_ALLOC;
        end else begin
          cur = used_list[found];
          orig = cur;
          used_list[found] = used_list[used_list.size() - 1];
          used_list.pop_back();
          free_list.push_back(cur);
          merged = 1;
          while (merged) begin
            merged = 0;
            cnt = free_list.size();
            for (int i = 0; i < cnt - 1; i++) begin
              if ((free_list[i].idx & ~1) == (cur.idx & ~1) &&
                  free_list[i].layer == cur.layer) begin
                free_list[i] = free_list[cnt - 2];
                free_list.pop_back();
                free_list.pop_back();
                cur.idx = cur.idx >> 1;
                cur.layer++;
                free_list.push_back(cur);
                merged = 1;
                break;
              end
            end
          end
          res.status = ST_OK;
          res.block_offset = OFF_W'(byte_off(orig));
          res.block_layer = LAYER_W'(orig.layer);
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.block_offset !== want.block_offset) begin
        $display("%0t: offset exp %h got %h", $time, want.block_offset,
                 got.block_offset);
        errors++;
      end
      if (got.block_layer !== want.block_layer) begin
        $display("%0t: layer exp %0d got %0d", $time, want.block_layer,
                 got.block_layer);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;

  alloc_scoreboard sb;
  int   send_idle_pct, recv_idle_pct;
  bit   hold_recv;
  longint cycles;

  buddy_block_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd20_000_000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int held;
    out_stall = 1'b0;
    held = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_recv && held < 40000) begin
        held++;
        out_stall <= 1'b1;
      end else begin
        if (!hold_recv) held = 0;
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // in_valid stays high after a take until the next request or a pause
  task automatic send_request(in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic do_alloc(int unsigned sz);
    in_t r;
    r = '0;
    r.req_type = REQ_ALLOC;
    r.size_bytes = SIZE_W'(sz);
    r.free_offset = OFF_W'($urandom);
    send_request(r);
  endtask

  task automatic do_free(int unsigned off);
    in_t r;
    r = '0;
    r.req_type = REQ_FREE;
    r.free_offset = OFF_W'(off);
    r.size_bytes = SIZE_W'($urandom);
    send_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // an allocate, or a free of an offset currently held (from the predictor's used list), inside one, or random
  task automatic random_request();
    int unsigned sz, pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(3))
        0: sz = $urandom_range(1, 1024);
        1: sz = $urandom_range(1, 16384);
        2: sz = $urandom_range(1, 262144);
        default: sz = $urandom_range(0, 4194303);
      endcase
      do_alloc(sz);
    end else if (pick < 88 && sb.used_list.size() != 0) begin
      do_free(32'(sb.byte_off(sb.used_list[$urandom_range(sb.used_list.size() - 1)])));
    end else if (pick < 94 && sb.used_list.size() != 0) begin
      // inside a block but not its start
      do_free(32'(sb.byte_off(sb.used_list[$urandom_range(sb.used_list.size() - 1)]))
              + 512);
    end else begin
      do_free($urandom_range(0, 4194303));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_recv = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    do_free(0);
    do_alloc(0);
    do_alloc(1);
    do_alloc(1024);
    do_alloc(1025);
    do_alloc(4194303);
    do_alloc(2097152);
    do_free(2048);
    do_free(0);
    do_free(1024);
    do_free(3072 + 512);
    do_free(4096);
    do_alloc(2097152);
    do_alloc(2097152);
    do_alloc(1);
    do_free(2097152);
    do_free(0);
    do_alloc(3000);
    do_alloc(65536);
    do_free(4194303);
    do_free(0);
    do_free(65536);
    drain();

    send_idle_pct = 8;  recv_idle_pct = 46;
    repeat (45) random_request();
    send_idle_pct = 46; recv_idle_pct = 8;
    repeat (45) random_request();
    send_idle_pct = 0;  recv_idle_pct = 0;
    hold_recv = 1;
    repeat (6) random_request();
    hold_recv = 0;
    drain();
    repeat (22) random_request();

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
